// ----- sv/sdeq_pkg.sv -----
// shared types and constants for the sorted double-ended queue
package sdeq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MIN = 2'd1,
    OP_REMOVE_MAX = 2'd2,
    OP_SEARCH     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                     opcode;
    logic signed [VALUE_W-1:0]   operand_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]   result_value;
    status_t                     status;
    logic [ENTRY_W-1:0]          entry_count;
  } out_req_t;

  // broadcast to every cell
  typedef struct packed {
    logic                        en;
    opcode_t                     op;
    logic signed [VALUE_W-1:0]   operand;
  } cell_ctrl_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic signed [VALUE_W-1:0]   value;
    logic                        occ;
    logic                        mark;
  } cell_link_t;

  // what a cell reports to the top level
  typedef struct packed {
    logic                        hit;
    logic                        last;
  } cell_flag_t;

endpackage

// ----- sv/sorted_double_ended_queue.sv -----
// sorted double-ended queue: a chain of compare-and-shift cells
//
// Holds up to DEPTH signed values in ascending order. Each request on the
// in_ channel (in_valid/in_stall, payload in_req) is one operation: insert,
// remove smallest, remove largest or search. Every request gives exactly one
// result request on the out_ channel (out_valid/out_stall, payload out_req)
// carrying the value, a status and the entry count after the operation.
// All cells compare against the operand and shift to a neighbour in the same
// cycle, so the result appears in the output register in the cycle after
// acceptance, and a new request can be taken every cycle while in_stall is
// low. Throughput is one request per cycle when the output does not stall.
// While a result sits in the output register and out_stall is high, in_stall
// is raised and no new request is taken; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the store and clears out_valid.
// Removal from an empty store and insert into a full store leave the store
// unchanged and report empty or full status with the most negative value.
module sorted_double_ended_queue import sdeq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  localparam logic signed [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

  logic                      in_accept;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_req_t                  out_req_r, out_req_nxt;
  logic                      full, empty;
  cell_ctrl_t                ctrl;
  cell_link_t                link [DEPTH];
  cell_flag_t                flag [DEPTH];
  cell_link_t                head_link, tail_link;
  logic [DEPTH-1:0]          occ_vec;
  logic                      found;
  logic signed [VALUE_W-1:0] max_value;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    ctrl.op      = in_req.opcode;
    ctrl.operand = in_req.operand_value;
    case (in_req.opcode) inside
      OP_INSERT:                    ctrl.en = in_accept && !full;
      OP_REMOVE_MIN, OP_REMOVE_MAX: ctrl.en = in_accept && !empty;
      default:                      ctrl.en = 1'b0;
    endcase
  end

  // chain ends
  assign head_link.value = in_req.operand_value;
  assign head_link.occ   = 1'b1;
  assign head_link.mark  = 1'b0;
  assign tail_link.value = in_req.operand_value;
  assign tail_link.occ   = 1'b0;
  assign tail_link.mark  = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = head_link;
    end else begin : g_left
      assign left_in = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = tail_link;
    end else begin : g_right
      assign right_in = link[i+1];
    end
    sdeq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_link  (left_in),
      .right_link (right_in),
      .link       (link[i]),
      .flag       (flag[i])
    );
    assign occ_vec[i] = link[i].occ;
  end

  always_comb begin
    found     = 1'b0;
    max_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found     = found | flag[i].hit;
      max_value = max_value | (flag[i].last ? link[i].value : '0);
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;
    if (in_accept) begin
      out_valid_nxt            = 1'b1;
      out_req_nxt.result_value = in_req.operand_value;
      out_req_nxt.status       = ST_DONE;
      case (in_req.opcode) inside
        OP_INSERT: begin
          if (full) begin
            out_req_nxt.result_value = MIN_VALUE;
            out_req_nxt.status       = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE_MIN, OP_REMOVE_MAX: begin
          if (empty) begin
            out_req_nxt.result_value = MIN_VALUE;
            out_req_nxt.status       = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            out_req_nxt.result_value =
              (in_req.opcode == OP_REMOVE_MIN) ? link[0].value : max_value;
          end
        end
        default: begin
          out_req_nxt.status = found ? ST_DONE : ST_MISSING;
        end
      endcase
      out_req_nxt.entry_count = ENTRY_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_occ_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == int'(count_r))
    else $error("cell occupancy disagrees with entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_req.opcode == OP_INSERT && !full |=>
      count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the store");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

// ----- sv/sdeq_cell.sv -----
// one storage cell of the sorted chain
module sdeq_cell import sdeq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left_link,
  input  cell_link_t right_link,
  output cell_link_t link,
  output cell_flag_t flag
);

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      occ_r, occ_nxt;
  logic                      mark;

  // set on every cell at or above the operand and on every free one
  assign mark = !occ_r || (value_r >= ctrl.operand);

  assign link.value = value_r;
  assign link.occ   = occ_r;
  assign link.mark  = mark;

  assign flag.hit  = occ_r && (value_r == ctrl.operand);
  assign flag.last = occ_r && !right_link.occ;

  always_comb begin
    value_nxt = value_r;
    occ_nxt   = occ_r;
    if (ctrl.en) begin
      case (ctrl.op)
        OP_INSERT: begin
          if (left_link.mark) begin
            value_nxt = left_link.value;
          end else if (mark) begin
            value_nxt = ctrl.operand;
          end
          occ_nxt = occ_r | left_link.occ;
        end
        OP_REMOVE_MIN: begin
          value_nxt = right_link.value;
          occ_nxt   = right_link.occ;
        end
        OP_REMOVE_MAX: begin
          occ_nxt = right_link.occ;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

endmodule
